// File: rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 digest core.
package sha1_pkg;

  localparam int ROUNDS  = 80;
  localparam int ROUND_W = 7;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [4:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // working variables a..e of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } vars_t;

endpackage

// File: rtl/sha1_round.sv
// One SHA-1 round and one step of the rolling message schedule.
module sha1_round
  import sha1_pkg::*;
(
  input  vars_t              v,
  input  logic [ROUND_W-1:0] rnd,
  input  logic [511:0]       sched,
  output vars_t              v_next,
  output logic [31:0]        w_new
);

  logic [31:0] w0, w2, w8, w13, wx, f, k, tmp;

  // sched holds W[t] in the top word, W[t+15] in the bottom word
  assign w0  = sched[511:480];
  assign w2  = sched[447:416];
  assign w8  = sched[255:224];
  assign w13 = sched[95:64];
  assign wx  = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd < ROUND_W'(20)) begin
      f = (v.b & v.c) | (~v.b & v.d);
      k = K0;
    end else if (rnd < ROUND_W'(40)) begin
      f = v.b ^ v.c ^ v.d;
      k = K1;
    end else if (rnd < ROUND_W'(60)) begin
      f = (v.b & v.c) | (v.b & v.d) | (v.c & v.d);
      k = K2;
    end else begin
      f = v.b ^ v.c ^ v.d;
      k = K3;
    end
  end

  assign tmp = {v.a[26:0], v.a[31:27]} + f + v.e + k + w0;

  always_comb begin
    v_next.a = tmp;
    v_next.b = v.a;
    v_next.c = {v.b[1:0], v.b[31:2]};
    v_next.d = v.c;
    v_next.e = v.d;
  end

endmodule

// File: rtl/sha1_message_digest_core.sv
// Top level of the streaming SHA-1 digest core: byte intake, padding and round sequencer.
//
// Streaming SHA-1 hasher. Each input transfer carries at most one message byte
// (byte_valid) and may end the message (last_item); an end transfer with no byte
// is allowed, so the empty message works. Every 64th byte starts a compression:
// the 80 rounds run in turn on the single shared round unit, and then the round
// variables are added into the chaining words in S_ADD. in_ready is low while a
// compression or the padding runs, and while S_DONE waits for the output
// register. After the last transfer the core pushes the 0x80 byte, zero bytes
// and the 64-bit big-endian bit length one byte per cycle while no compression
// runs (with a step that pushes no byte as the zeros give way to the length),
// which adds 9 to 72 bytes and one or two compressions. The digest then lands
// in an output register (digest_w0 .. digest_w4, w0 first; w0:w1 is the 64-bit
// short form) and the core returns to the initial chaining values, so new
// message bytes are taken while the digest waits for out_ready. The message
// buffer is a 512-bit shift line that also serves as the rolling schedule
// during the rounds. The byte count wraps modulo 2^64.
module sha1_message_digest_core
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_w0,
  output logic [31:0] digest_w1,
  output logic [31:0] digest_w2,
  output logic [31:0] digest_w3,
  output logic [31:0] digest_w4
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_MARK,
    P_ZERO,
    P_LEN
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic [4:0][31:0]   chain;
  logic [63:0]        len;
  logic [63:0]        len_next;
  logic [63:0]        bitlen;
  logic [2:0]         idx;
  logic               padding;
  logic               pad_done;
  logic [511:0]       msg;
  vars_t              vars;
  vars_t              vars_next;
  logic [31:0]        w_new;
  logic [ROUND_W-1:0] rnd;
  logic [4:0][31:0]   digest;

  logic       in_fire;
  logic       push_en;
  logic [7:0] push_byte;
  logic       block_full;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign digest_w0 = digest[0];
  assign digest_w1 = digest[1];
  assign digest_w2 = digest[2];
  assign digest_w3 = digest[3];
  assign digest_w4 = digest[4];

  // byte source for the buffer: message bytes when idle, pad bytes in S_PAD, none otherwise
  always_comb begin
    push_en   = 1'b0;
    push_byte = data_byte;
    case (state)
      S_IDLE: begin
        push_en = in_fire && byte_valid;
      end
      S_PAD: begin
        case (phase)
          P_MARK: begin
            push_en   = 1'b1;
            push_byte = PAD_BYTE;
          end
          P_ZERO: begin
            push_en   = (len[5:0] != 6'd56);
            push_byte = 8'h00;
          end
          P_LEN: begin
            push_en   = 1'b1;
            push_byte = bitlen[63:56];
          end
          default: begin
            push_en = 1'b0;
          end
        endcase
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign len_next   = len + 64'd1;
  assign block_full = push_en && (len_next[5:0] == 6'd0);

  sha1_round u_round (
    .v      (vars),
    .rnd    (rnd),
    .sched  (msg),
    .v_next (vars_next),
    .w_new  (w_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_MARK;
      chain     <= H_INIT;
      len       <= 64'd0;
      idx       <= 3'd0;
      padding   <= 1'b0;
      pad_done  <= 1'b0;
      out_valid <= 1'b0;
      rnd       <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      if (push_en) begin
        msg <= {msg[503:0], push_byte};
        len <= len_next;
      end

      // a filled block starts the rounds from the current chaining words
      if (block_full) begin
        vars.a <= chain[0];
        vars.b <= chain[1];
        vars.c <= chain[2];
        vars.d <= chain[3];
        vars.e <= chain[4];
        rnd    <= '0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (last_item) begin
              padding  <= 1'b1;
              pad_done <= 1'b0;
              phase    <= P_MARK;
            end
            if (block_full) begin
              state <= S_ROUND;
            end else if (last_item) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          case (phase)
            P_MARK: begin
              bitlen <= {len[60:0], 3'b000};
              phase  <= P_ZERO;
            end
            P_ZERO: begin
              if (len[5:0] == 6'd56) begin
                phase <= P_LEN;
                idx   <= 3'd0;
              end
            end
            P_LEN: begin
              bitlen <= {bitlen[55:0], 8'h00};
              idx    <= idx + 3'd1;
              if (idx == 3'd7) begin
                pad_done <= 1'b1;
              end
            end
            default: begin
              phase <= P_MARK;
            end
          endcase
          if (block_full) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          vars <= vars_next;
          msg  <= {msg[479:0], w_new};
          rnd  <= rnd + ROUND_W'(1);
          if (rnd == ROUND_W'(ROUNDS - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + vars.a;
          chain[1] <= chain[1] + vars.b;
          chain[2] <= chain[2] + vars.c;
          chain[3] <= chain[3] + vars.d;
          chain[4] <= chain[4] + vars.e;
          if (pad_done) begin
            state <= S_DONE;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || out_ready) begin
            digest    <= chain;
            out_valid <= 1'b1;
            chain     <= H_INIT;
            len       <= 64'd0;
            padding   <= 1'b0;
            pad_done  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
